// ----- rtl/srs_pkg.sv -----
package srs_pkg;

    localparam int STACK_DEPTH  = 256;
    localparam int SYMBOL_SLOTS = 256;
    localparam int ADDR_WIDTH   = 64;

    localparam int FIELD_W   = 64;
    localparam int COUNT_W   = 32;
    localparam int CMD_W     = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_SEL_LSB = 3;
    localparam int REG_SEL_W = CFG_ADDR_W - REG_SEL_LSB;

    localparam int STK_IDX_W = $clog2(STACK_DEPTH);
    localparam int STK_CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SYM_IDX_W = $clog2(SYMBOL_SLOTS);
    localparam int SYM_CNT_W = $clog2(SYMBOL_SLOTS + 1);

    localparam logic [FIELD_W-1:0] ADDR_MASK = {FIELD_W{1'b1}} >> (FIELD_W - ADDR_WIDTH);

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CALL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RETURN = 2'd2;

    localparam logic [REG_SEL_W-1:0] REG_EXEC_LOW   = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_EXEC_HIGH  = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_LIB_LOW    = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_LIB_HIGH   = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_LIB_LOADED = 3'd4;

    typedef struct packed {
        logic [FIELD_W-1:0] exec_low;
        logic [FIELD_W-1:0] exec_high;
        logic [FIELD_W-1:0] lib_low;
        logic [FIELD_W-1:0] lib_high;
        logic               lib_loaded;
    } cfg_t;

    typedef struct packed {
        logic               load;
        logic               start;
        logic [FIELD_W-1:0] addr;
    } sym_req_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } sym_rsp_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [FIELD_W-1:0] data;
    } stk_req_t;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [FIELD_W-1:0] rdata;
    } stk_rsp_t;

    function automatic logic strictly_inside(
        input logic [FIELD_W-1:0] a,
        input logic [FIELD_W-1:0] lo,
        input logic [FIELD_W-1:0] hi
    );
        logic [FIELD_W-1:0] am;
        logic [FIELD_W-1:0] lm;
        logic [FIELD_W-1:0] hm;
        am = a & ADDR_MASK;
        lm = lo & ADDR_MASK;
        hm = hi & ADDR_MASK;
        return (am > lm) && (am < hm);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(
        input logic [COUNT_W-1:0] v,
        input logic [1:0]         inc
    );
        logic [COUNT_W:0] sum;
        sum = {1'b0, v} + (COUNT_W+1)'(inc);
        return sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
    endfunction

endpackage

// ----- rtl/shadow_return_stack_checker.sv -----
// Every command passes through the execute, finish and output states; a return that pops
// also passes through the pop state, and a call whose return address is inside the
// executable range scans the symbol table, one entry per comparison, until a hit or the end.
// Only one event is in flight at a time; cmd_stall is high from transfer until the result is
// loaded into the output register.
// Reset clears configuration, state, counters, pointers and result valid, not the memories.
module shadow_return_stack_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [srs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [srs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [srs_pkg::CMD_W-1:0]          command,
    input  logic [srs_pkg::FIELD_W-1:0]        symbol_address,
    input  logic [srs_pkg::FIELD_W-1:0]        target,
    input  logic [srs_pkg::FIELD_W-1:0]        next_addr,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               gadget_found,
    output logic                               stack_underflow,
    output logic                               stack_overflow,
    output logic                               symbol_table_full,
    output logic                               imbalance_warning,
    output logic [srs_pkg::COUNT_W-1:0]        calls_seen,
    output logic [srs_pkg::COUNT_W-1:0]        returns_seen
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    srs_pkg::cfg_t      cfg;
    srs_pkg::sym_req_t  sym_req;
    srs_pkg::sym_rsp_t  sym_rsp;
    srs_pkg::stk_req_t  stk_req;
    srs_pkg::stk_rsp_t  stk_rsp;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [srs_pkg::CMD_W-1:0]     cmd_reg;
    logic [srs_pkg::FIELD_W-1:0]   addr_reg;
    logic [srs_pkg::FIELD_W-1:0]   nxt_reg;
    logic                          nxt_exec_reg;
    logic                          nxt_lib_reg;
    logic                          tgt_exec_reg;
    logic                          tgt_lib_reg;
    logic                          known_reg;
    logic                          gadget_reg;
    logic                          under_reg;
    logic                          over_reg;
    logic                          full_reg;
    logic [srs_pkg::COUNT_W-1:0]   call_total_reg;
    logic [srs_pkg::COUNT_W-1:0]   return_total_reg;
    logic                          rsp_valid_reg;

    logic                          accept;
    logic                          tracked;
    logic                          push_call;
    logic [1:0]                    call_inc;
    logic [1:0]                    ret_inc;
    logic                          out_load;

    srs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srs_sym_table u_sym_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sym_req),
        .rsp   (sym_rsp)
    );

    srs_ret_stack u_ret_stack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (stk_req),
        .rsp   (stk_rsp)
    );

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_load  = (state_reg == S_OUT) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;

    assign tracked   = nxt_exec_reg && known_reg;
    assign push_call = (cmd_reg == srs_pkg::CMD_CALL) && tracked && !tgt_lib_reg;

    always_comb
    begin
        call_inc = 2'd0;
        ret_inc  = 2'd0;
        if (cmd_reg == srs_pkg::CMD_CALL)
        begin
            call_inc = 2'(push_call) + 2'(!(tracked && tgt_lib_reg) && nxt_lib_reg);
        end
        if (cmd_reg == srs_pkg::CMD_RETURN)
        begin
            ret_inc = 2'(tgt_exec_reg) + 2'(tgt_lib_reg);
        end
    end

    always_comb
    begin
        sym_req.load  = (state_reg == S_EXEC) && (cmd_reg == srs_pkg::CMD_LOAD);
        sym_req.start = (state_reg == S_EXEC) && (cmd_reg == srs_pkg::CMD_CALL) && nxt_exec_reg;
        sym_req.addr  = addr_reg;

        stk_req.pop   = (state_reg == S_EXEC) && (cmd_reg == srs_pkg::CMD_RETURN)
                        && tgt_exec_reg;
        stk_req.push  = (state_reg == S_FIN) && push_call;
        stk_req.data  = nxt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sym_req.start)
                begin
                    state_next = S_SCAN;
                end
                else if (stk_req.pop && !stk_rsp.empty)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                if (sym_rsp.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_POP:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            call_total_reg   <= '0;
            return_total_reg <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN)
            begin
                call_total_reg   <= srs_pkg::sat_add(call_total_reg, call_inc);
                return_total_reg <= srs_pkg::sat_add(return_total_reg, ret_inc);
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= command;
            addr_reg     <= (command == srs_pkg::CMD_LOAD) ? (symbol_address & srs_pkg::ADDR_MASK)
                                                          : (target & srs_pkg::ADDR_MASK);
            nxt_reg      <= next_addr & srs_pkg::ADDR_MASK;
            nxt_exec_reg <= srs_pkg::strictly_inside(next_addr, cfg.exec_low, cfg.exec_high);
            tgt_exec_reg <= srs_pkg::strictly_inside(target, cfg.exec_low, cfg.exec_high);
            nxt_lib_reg  <= cfg.lib_loaded
                            && srs_pkg::strictly_inside(next_addr, cfg.lib_low, cfg.lib_high);
            tgt_lib_reg  <= cfg.lib_loaded
                            && srs_pkg::strictly_inside(target, cfg.lib_low, cfg.lib_high);
            known_reg    <= 1'b0;
            gadget_reg   <= 1'b0;
            under_reg    <= 1'b0;
            over_reg     <= 1'b0;
            full_reg     <= 1'b0;
        end
        if (state_reg == S_EXEC)
        begin
            if (sym_req.load && sym_rsp.full)
            begin
                full_reg <= 1'b1;
            end
            if (stk_req.pop && stk_rsp.empty)
            begin
                under_reg <= 1'b1;
            end
        end
        if ((state_reg == S_SCAN) && sym_rsp.done)
        begin
            known_reg <= sym_rsp.hit;
        end
        if (state_reg == S_POP)
        begin
            gadget_reg <= (stk_rsp.rdata != addr_reg);
        end
        if ((state_reg == S_FIN) && push_call && stk_rsp.full)
        begin
            over_reg <= 1'b1;
        end
        if (out_load)
        begin
            gadget_found      <= gadget_reg;
            stack_underflow   <= under_reg;
            stack_overflow    <= over_reg;
            symbol_table_full <= full_reg;
            imbalance_warning <= cfg.lib_loaded && (return_total_reg > call_total_reg);
            calls_seen        <= call_total_reg;
            returns_seen      <= return_total_reg;
        end
    end

endmodule

// ----- rtl/srs_cfg.sv -----
module srs_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [srs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [srs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    output srs_pkg::cfg_t                      cfg
);

    srs_pkg::cfg_t                  cfg_reg;
    logic [srs_pkg::REG_SEL_W-1:0]  sel;
    logic                           wr_en;

    assign sel    = paddr[srs_pkg::CFG_ADDR_W-1:srs_pkg::REG_SEL_LSB];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (sel)
                srs_pkg::REG_EXEC_LOW:   cfg_reg.exec_low   <= pwdata;
                srs_pkg::REG_EXEC_HIGH:  cfg_reg.exec_high  <= pwdata;
                srs_pkg::REG_LIB_LOW:    cfg_reg.lib_low    <= pwdata;
                srs_pkg::REG_LIB_HIGH:   cfg_reg.lib_high   <= pwdata;
                srs_pkg::REG_LIB_LOADED: cfg_reg.lib_loaded <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            srs_pkg::REG_EXEC_LOW:   prdata = cfg_reg.exec_low;
            srs_pkg::REG_EXEC_HIGH:  prdata = cfg_reg.exec_high;
            srs_pkg::REG_LIB_LOW:    prdata = cfg_reg.lib_low;
            srs_pkg::REG_LIB_HIGH:   prdata = cfg_reg.lib_high;
            srs_pkg::REG_LIB_LOADED:
                prdata = {{(srs_pkg::CFG_DATA_W-1){1'b0}}, cfg_reg.lib_loaded};
            default:                 prdata = '0;
        endcase
    end

endmodule

// ----- rtl/srs_sym_table.sv -----
module srs_sym_table
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  srs_pkg::sym_req_t     req,
    output srs_pkg::sym_rsp_t     rsp
);

    logic [srs_pkg::FIELD_W-1:0]   mem [srs_pkg::SYMBOL_SLOTS];
    logic [srs_pkg::FIELD_W-1:0]   rdata_reg;
    logic [srs_pkg::SYM_CNT_W-1:0] fill_reg;
    logic [srs_pkg::SYM_CNT_W-1:0] rd_idx_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          hit_reg;
    logic [srs_pkg::SYM_IDX_W-1:0] rd_addr;
    logic                          full;

    assign full    = (fill_reg == srs_pkg::SYM_CNT_W'(srs_pkg::SYMBOL_SLOTS));
    assign rd_addr = req.start ? '0 : rd_idx_reg[srs_pkg::SYM_IDX_W-1:0];

    assign rsp.done = done_reg;
    assign rsp.hit  = hit_reg;
    assign rsp.full = full;

    // One entry is read per cycle; while busy, rdata_reg holds entry rd_idx_reg - 1.
    always_ff @(posedge clk)
    begin
        if (req.load && !full)
        begin
            mem[fill_reg[srs_pkg::SYM_IDX_W-1:0]] <= req.addr;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            rd_idx_reg <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.load && !full)
            begin
                fill_reg <= fill_reg + srs_pkg::SYM_CNT_W'(1);
            end
            if (req.start)
            begin
                hit_reg <= 1'b0;
                if (fill_reg == '0)
                begin
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    busy_reg   <= 1'b1;
                    rd_idx_reg <= srs_pkg::SYM_CNT_W'(1);
                end
            end
            else if (busy_reg)
            begin
                if (rdata_reg == req.addr)
                begin
                    done_reg <= 1'b1;
                    hit_reg  <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else if (rd_idx_reg < fill_reg)
                begin
                    rd_idx_reg <= rd_idx_reg + srs_pkg::SYM_CNT_W'(1);
                end
                else
                begin
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- rtl/srs_ret_stack.sv -----
module srs_ret_stack
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  srs_pkg::stk_req_t     req,
    output srs_pkg::stk_rsp_t     rsp
);

    logic [srs_pkg::FIELD_W-1:0]   mem [srs_pkg::STACK_DEPTH];
    logic [srs_pkg::FIELD_W-1:0]   rdata_reg;
    logic [srs_pkg::STK_CNT_W-1:0] sp_reg;
    logic [srs_pkg::STK_CNT_W-1:0] sp_dec;
    logic                          empty;
    logic                          full;

    assign sp_dec = sp_reg - srs_pkg::STK_CNT_W'(1);
    assign empty  = (sp_reg == '0);
    assign full   = (sp_reg == srs_pkg::STK_CNT_W'(srs_pkg::STACK_DEPTH));

    assign rsp.empty = empty;
    assign rsp.full  = full;
    assign rsp.rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.push && !full)
        begin
            mem[sp_reg[srs_pkg::STK_IDX_W-1:0]] <= req.data;
        end
        if (req.pop && !empty)
        begin
            rdata_reg <= mem[sp_dec[srs_pkg::STK_IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else if (req.push && !full)
        begin
            sp_reg <= sp_reg + srs_pkg::STK_CNT_W'(1);
        end
        else if (req.pop && !empty)
        begin
            sp_reg <= sp_dec;
        end
    end

endmodule

// ----- rtl/srs_checker.sv -----
module srs_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_stall,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic                          gadget_found,
    input  logic                          stack_underflow,
    input  logic                          stack_overflow,
    input  logic                          symbol_table_full,
    input  logic                          imbalance_warning,
    input  logic [srs_pkg::COUNT_W-1:0]   calls_seen,
    input  logic [srs_pkg::COUNT_W-1:0]   returns_seen
);

    // A stalled result stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // Only one event is worked on at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken while another is in flight");

    // A return either finds the stack empty or compares the popped entry, never both.
    a_gadget_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(gadget_found && stack_underflow))
        else $error("gadget flagged on an empty stack");

    // The overflow flag of a call never appears together with a flag of a return or a load.
    a_flag_groups: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(stack_overflow && (gadget_found || stack_underflow || symbol_table_full)))
        else $error("flags of different commands in one result");

    a_imbalance: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && imbalance_warning |-> returns_seen > calls_seen)
        else $error("imbalance warning without more returns than calls");

endmodule

bind shadow_return_stack_checker srs_checker u_srs_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd_stall         (cmd_stall),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .gadget_found      (gadget_found),
    .stack_underflow   (stack_underflow),
    .stack_overflow    (stack_overflow),
    .symbol_table_full (symbol_table_full),
    .imbalance_warning (imbalance_warning),
    .calls_seen        (calls_seen),
    .returns_seen      (returns_seen)
);
